FILE: src/tlbfr_pkg.sv
// shared constants, types and helper functions of the fifo-replacement tlb
`default_nettype none

package tlbfr_pkg;

    localparam int TLB_DEPTH  = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int VADDR_BITS = 48;

    localparam int TAG_W   = VADDR_BITS - PAGE_SHIFT;
    localparam int SLOT_W  = $clog2(TLB_DEPTH);
    localparam int OCC_W   = $clog2(TLB_DEPTH + 1);
    localparam int LIMIT_W = 7;
    localparam int CMP_W   = (LIMIT_W > OCC_W) ? LIMIT_W : OCC_W;
    localparam int CNT_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
    } cam_ctl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    // entry count of zero acts as one, above the depth acts as the depth
    function automatic logic [CMP_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] n);
        logic [CMP_W-1:0] n_ext;
        n_ext = CMP_W'(n);
        if (n_ext == '0)
        begin
            clamp_limit = CMP_W'(1);
        end
        else if (n_ext > CMP_W'(TLB_DEPTH))
        begin
            clamp_limit = CMP_W'(TLB_DEPTH);
        end
        else
        begin
            clamp_limit = n_ext;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/tlbfr_ifs.sv
// valid/ready channel interfaces for request, response and configuration
`default_nettype none

interface tlbfr_req_if import tlbfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [VADDR_BITS-1:0] vaddr;

    modport source (output valid, output func, output vaddr, input ready);
    modport sink (input valid, input func, input vaddr, output ready);
endinterface

interface tlbfr_rsp_if import tlbfr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [CNT_W-1:0] access_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;

    modport source (output valid, output hit, output access_count, output hit_count,
                    output miss_count, input ready);
    modport sink (input valid, input hit, input access_count, input hit_count,
                  input miss_count, output ready);
endinterface

interface tlbfr_cfg_if import tlbfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] entries_in_use;

    modport source (output valid, output entries_in_use, input ready);
    modport sink (input valid, input entries_in_use, output ready);
endinterface

`default_nettype wire

FILE: src/tlbfr_cam.sv
// fully associative tag store with valid bits and parallel page compare
`default_nettype none

module tlbfr_cam import tlbfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [TAG_W-1:0] page,
    output logic                  match,
    input  wire cam_ctl_t         ctl
);

    logic [TLB_DEPTH-1:0] valid_reg;
    logic [TLB_DEPTH-1:0] valid_next;
    logic [TAG_W-1:0]     tag_reg [TLB_DEPTH];
    logic [TLB_DEPTH-1:0] hit_vec;

    always_comb
    begin
        for (int i = 0; i < TLB_DEPTH; i++)
        begin
            hit_vec[i] = valid_reg[i] && (tag_reg[i] == page);
        end
        match = |hit_vec;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            valid_next[ctl.slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && !ctl.clear)
        begin
            tag_reg[ctl.slot] <= ctl.tag;
        end
    end

endmodule

`default_nettype wire

FILE: src/tlb_lookup_fifo_replace.sv
// top level: fully associative tlb with fifo replacement and saturating counters
//
// channels: req carries func and vaddr, rsp returns hit and the
// access, hit and miss counts after the beat, cfg writes entries_in_use.
// func 0 looks up page = vaddr >> 12 in all 64 entries at once;
// a miss inserts the page, filling free slots first and then replacing the
// oldest inserted entry. func 1 empties the tlb and zeroes every count.
// a request beat is registered on acceptance, then compared and resolved
// once the response register is free, and its response is registered.
// one request beat can be accepted every cycle unless rsp stalls; the tag
// compare and update are combinational. while rsp is stalled the response holds,
// one more request waits in the input register, and req.ready drops.
// cfg.ready is always high; write entries_in_use only while no beat is in
// flight and follow it with a clear. reset empties the tlb, zeroes all counts
// and sets entries_in_use to 64; no response is pending after reset.
`default_nettype none

module tlb_lookup_fifo_replace import tlbfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tlbfr_req_if.sink     req,
    tlbfr_rsp_if.source   rsp,
    tlbfr_cfg_if.sink     cfg
);

    logic [CMP_W-1:0]  limit_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_func_reg;
    logic [TAG_W-1:0]  s1_page_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic              hit_reg;
    logic              hit_next;
    logic [CNT_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  acc_next;
    logic [CNT_W-1:0]  hits_reg;
    logic [CNT_W-1:0]  hits_next;
    logic [CNT_W-1:0]  miss_reg;
    logic [CNT_W-1:0]  miss_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [SLOT_W-1:0] oldest_reg;
    logic [SLOT_W-1:0] oldest_next;
    logic              out_free;
    logic              fire;
    logic              accept;
    logic              match;
    logic [SLOT_W-1:0] victim;
    logic [CMP_W-1:0]  victim_inc;
    cam_ctl_t          cam_ctl;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit          = hit_reg;
    assign rsp.access_count = acc_reg;
    assign rsp.hit_count    = hits_reg;
    assign rsp.miss_count   = miss_reg;

    tlbfr_cam u_cam
    (
        .clk   (clk),
        .rst_n (rst_n),
        .page  (s1_page_reg),
        .match (match),
        .ctl   (cam_ctl)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        hit_next    = hit_reg;
        acc_next    = acc_reg;
        hits_next   = hits_reg;
        miss_next   = miss_reg;
        occ_next    = occ_reg;
        oldest_next = oldest_reg;
        cam_ctl     = '0;
        cam_ctl.tag = s1_page_reg;

        victim     = (CMP_W'(oldest_reg) < limit_reg) ? oldest_reg : '0;
        victim_inc = CMP_W'(victim) + CMP_W'(1);

        if (fire)
        begin
            if (s1_func_reg == FUNC_CLEAR)
            begin
                cam_ctl.clear = 1'b1;
                hit_next      = 1'b0;
                acc_next      = '0;
                hits_next     = '0;
                miss_next     = '0;
                occ_next      = '0;
                oldest_next   = '0;
            end
            else
            begin
                acc_next = sat_inc(acc_reg);
                hit_next = match;
                if (match)
                begin
                    hits_next = sat_inc(hits_reg);
                end
                else
                begin
                    miss_next     = sat_inc(miss_reg);
                    cam_ctl.wr_en = 1'b1;
                    if (CMP_W'(occ_reg) < limit_reg)
                    begin
                        cam_ctl.slot = occ_reg[SLOT_W-1:0];
                        occ_next     = occ_reg + OCC_W'(1);
                    end
                    else
                    begin
                        cam_ctl.slot = victim;
                        oldest_next  = (victim_inc >= limit_reg) ? '0 : victim_inc[SLOT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= clamp_limit(LIMIT_RESET);
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            acc_reg       <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            occ_reg       <= '0;
            oldest_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                limit_reg <= clamp_limit(cfg.entries_in_use);
            end
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_reg       <= hit_next;
            acc_reg       <= acc_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            occ_reg       <= occ_next;
            oldest_reg    <= oldest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= req.func;
            s1_page_reg <= req.vaddr[VADDR_BITS-1:PAGE_SHIFT];
        end
    end

endmodule

`default_nettype wire

FILE: bench/tlb_lookup_fifo_replace_tb.sv
// self-checking bench for the fifo-replacement tlb: directed table, then random phases
module tlb_lookup_fifo_replace_tb import tlbfr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int STALL_AFTER = 400;
    localparam int STALL_CYCLES = 250;

    typedef logic [TAG_W-1:0]      tag_t;
    typedef logic [PAGE_SHIFT-1:0] offset_t;
    typedef logic [VADDR_BITS-1:0] vaddr_t;
    typedef logic [LIMIT_W-1:0]    limit_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] accesses;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } tlb_result_t;

    typedef enum logic [1:0] {ROW_ACCESS, ROW_CLEAR, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        vaddr_t      addr;
        limit_t      limit;
        logic        typed;
        tlb_result_t want;
    } row_t;

    localparam row_t DIRECTED [28] = '{
        '{ROW_ACCESS, 48'h0000_0000_0000, 7'd0, 1'b1, '{1'b0, 32'd1, 32'd0, 32'd1}},
        '{ROW_ACCESS, 48'h0000_0000_0FFF, 7'd0, 1'b1, '{1'b1, 32'd2, 32'd1, 32'd1}},
        '{ROW_ACCESS, 48'hFFFF_FFFF_FFFF, 7'd0, 1'b1, '{1'b0, 32'd3, 32'd1, 32'd2}},
        '{ROW_ACCESS, 48'hFFFF_FFFF_F000, 7'd0, 1'b1, '{1'b1, 32'd4, 32'd2, 32'd2}},
        '{ROW_CLEAR,  48'hFFFF_FFFF_FFFF, 7'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 32'd0}},
        '{ROW_ACCESS, 48'hFFFF_FFFF_FFFF, 7'd0, 1'b1, '{1'b0, 32'd1, 32'd0, 32'd1}},
        '{ROW_CFG,    48'h0000_0000_0000, 7'd2, 1'b0, '0},
        '{ROW_CLEAR,  48'h0000_0000_0000, 7'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 32'd0}},
        '{ROW_ACCESS, 48'h0000_0000_1000, 7'd0, 1'b1, '{1'b0, 32'd1, 32'd0, 32'd1}},
        '{ROW_ACCESS, 48'h0000_0000_2000, 7'd0, 1'b1, '{1'b0, 32'd2, 32'd0, 32'd2}},
        '{ROW_ACCESS, 48'h0000_0000_3000, 7'd0, 1'b1, '{1'b0, 32'd3, 32'd0, 32'd3}},
        '{ROW_ACCESS, 48'h0000_0000_1000, 7'd0, 1'b1, '{1'b0, 32'd4, 32'd0, 32'd4}},
        '{ROW_ACCESS, 48'h0000_0000_3ABC, 7'd0, 1'b1, '{1'b1, 32'd5, 32'd1, 32'd4}},
        '{ROW_CFG,    48'h0000_0000_0000, 7'd0, 1'b0, '0},
        '{ROW_CLEAR,  48'h0000_0000_0000, 7'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 32'd0}},
        '{ROW_ACCESS, 48'h0000_0000_5000, 7'd0, 1'b1, '{1'b0, 32'd1, 32'd0, 32'd1}},
        '{ROW_ACCESS, 48'h0000_0000_5FFF, 7'd0, 1'b1, '{1'b1, 32'd2, 32'd1, 32'd1}},
        '{ROW_ACCESS, 48'h0000_0000_6000, 7'd0, 1'b1, '{1'b0, 32'd3, 32'd1, 32'd2}},
        '{ROW_ACCESS, 48'h0000_0000_5000, 7'd0, 1'b1, '{1'b0, 32'd4, 32'd1, 32'd3}},
        '{ROW_CFG,    48'h0000_0000_0000, 7'd127, 1'b0, '0},
        '{ROW_ACCESS, 48'h0000_0000_6000, 7'd0, 1'b0, '0},
        '{ROW_ACCESS, 48'h0000_0000_7000, 7'd0, 1'b0, '0},
        '{ROW_CFG,    48'h0000_0000_0000, 7'd1, 1'b0, '0},
        '{ROW_ACCESS, 48'h0000_0000_7000, 7'd0, 1'b0, '0},
        '{ROW_ACCESS, 48'h0000_0000_8000, 7'd0, 1'b0, '0},
        '{ROW_ACCESS, 48'h0000_0000_6000, 7'd0, 1'b0, '0},
        '{ROW_ACCESS, 48'h5555_5555_5555, 7'd0, 1'b0, '0},
        '{ROW_ACCESS, 48'hAAAA_AAAA_AAAA, 7'd0, 1'b0, '0}
    };

    localparam limit_t LIMIT_SWEEP [8] = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd63, 7'd65, 7'd3, 7'd64};

    logic clk;
    logic rst_n;

    tlbfr_req_if req_ch ();
    tlbfr_rsp_if rsp_ch ();
    tlbfr_cfg_if cfg_ch ();

    tlb_lookup_fifo_replace u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow copy of the tlb
    tag_t                  shadow_tag [TLB_DEPTH];
    logic [TLB_DEPTH-1:0]  shadow_valid;
    int unsigned           fill_level;
    int unsigned           next_victim;
    logic [CNT_W-1:0]      acc_total;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    limit_t                limit_reg;

    tlb_result_t pending_results [$];
    int          mismatches;
    int          sent_items;
    int          cycle_count;
    bit          quiet;
    bit          rsp_hold;

    function automatic int unsigned active_entries(input limit_t v);
        if (v == '0)
        begin
            return 1;
        end
        else if (int'(v) > TLB_DEPTH)
        begin
            return TLB_DEPTH;
        end
        return int'(v);
    endfunction

    function automatic tlb_result_t lookup_predict(input logic f, input vaddr_t va);
        tag_t        page;
        int unsigned lim;
        int unsigned slot;
        bit          found;
        tlb_result_t r;
        page = va[VADDR_BITS-1:PAGE_SHIFT];
        found = 1'b0;
        r = '0;
        if (f == FUNC_CLEAR)
        begin
            shadow_valid = '0;
            fill_level = 0;
            next_victim = 0;
            acc_total = '0;
            hit_total = '0;
            miss_total = '0;
        end
        else
        begin
            for (int i = 0; i < TLB_DEPTH; i++)
            begin
                if (shadow_valid[i] && shadow_tag[i] == page)
                begin
                    found = 1'b1;
                end
            end
            if (acc_total != CNT_MAX)
            begin
                acc_total++;
            end
            if (found)
            begin
                if (hit_total != CNT_MAX)
                begin
                    hit_total++;
                end
            end
            else
            begin
                if (miss_total != CNT_MAX)
                begin
                    miss_total++;
                end
                lim = active_entries(limit_reg);
                if (fill_level < lim)
                begin
                    slot = fill_level;
                    fill_level++;
                end
                else
                begin
                    slot = (next_victim < lim) ? next_victim : 0;
                    next_victim = (slot + 1 >= lim) ? 0 : slot + 1;
                end
                shadow_tag[slot] = page;
                shadow_valid[slot] = 1'b1;
            end
            r.hit = found;
        end
        r.accesses = acc_total;
        r.hits = hit_total;
        r.misses = miss_total;
        return r;
    endfunction

    task automatic send_item(input logic f, input vaddr_t va, input logic typed,
                             input tlb_result_t want);
        int unsigned gap;
        tlb_result_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.vaddr <= va;
        predicted = lookup_predict(f, va);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        do @(posedge clk); while (!req_ch.ready);
        sent_items++;
    endtask

    task automatic set_limit(input limit_t v);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.entries_in_use <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_reg = v;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // response side: random gaps per beat, plus the long hold below
    initial
    begin
        int unsigned gap;
        tlb_result_t got;
        tlb_result_t want;
        gap = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp_ch.valid && rsp_ch.ready)
                begin
                    got.hit = rsp_ch.hit;
                    got.accesses = rsp_ch.access_count;
                    got.hits = rsp_ch.hit_count;
                    got.misses = rsp_ch.miss_count;
                    if (pending_results.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"unexpected response beat: ",
                                      "hit %0d acc %0d hits %0d misses %0d"},
                                     got.hit, got.accesses, got.hits, got.misses);
                        end
                    end
                    else
                    begin
                        want = pending_results.pop_front();
                        if (got.hit !== want.hit || got.accesses !== want.accesses ||
                            got.hits !== want.hits || got.misses !== want.misses)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                            begin
                                $display({"mismatch: hit %0d/%0d acc %0d/%0d ",
                                          "hits %0d/%0d misses %0d/%0d (exp/got)"},
                                         want.hit, got.hit, want.accesses, got.accesses,
                                         want.hits, got.hits, want.misses, got.misses);
                            end
                        end
                    end
                    gap = quiet ? 0 : $urandom_range(0, 17);
                end
                else if (gap != 0)
                begin
                    gap--;
                end
                rsp_ch.ready <= (gap == 0) && !rsp_hold;
            end
        end
    end

    // long response stall so the request side backs up
    initial
    begin
        rsp_hold = 1'b0;
        while (sent_items < STALL_AFTER) @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin
        limit_t      lim_val;
        int unsigned eff;
        int unsigned pick;
        tag_t        page_pool [$];
        tag_t        pg;
        offset_t     off;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_ACCESS;
        req_ch.vaddr = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.entries_in_use = '0;
        quiet = 1'b0;
        mismatches = 0;
        sent_items = 0;
        shadow_valid = '0;
        fill_level = 0;
        next_victim = 0;
        acc_total = '0;
        hit_total = '0;
        miss_total = '0;
        limit_reg = LIMIT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                set_limit(DIRECTED[i].limit);
            end
            else
            begin
                send_item(DIRECTED[i].kind == ROW_CLEAR ? FUNC_CLEAR : FUNC_ACCESS,
                          DIRECTED[i].addr, DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            lim_val = (p < 8) ? LIMIT_SWEEP[p] : limit_t'($urandom_range(0, 127));
            set_limit(lim_val);
            eff = active_entries(lim_val);
            quiet = ($urandom_range(0, 3) == 0);
            // some phases skip the clear to keep stale entries across the limit change
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(FUNC_CLEAR, vaddr_t'({$urandom, $urandom}), 1'b0, '0);
            end
            page_pool.delete();
            repeat ($urandom_range(1, 2 * eff))
                page_pool.insert(page_pool.size(), tag_t'({$urandom, $urandom}));
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                off = offset_t'($urandom);
                pg = page_pool[$urandom_range(0, page_pool.size() - 1)];
                if (pick < 2)
                begin
                    send_item(FUNC_CLEAR, vaddr_t'({$urandom, $urandom}), 1'b0, '0);
                end
                else if (pick < 10)
                begin
                    // neighbor page, one tag bit off
                    pg = pg ^ (tag_t'(1) << $urandom_range(0, TAG_W - 1));
                    send_item(FUNC_ACCESS, {pg, off}, 1'b0, '0);
                end
                else if (pick < 20)
                begin
                    send_item(FUNC_ACCESS, vaddr_t'({$urandom, $urandom}), 1'b0, '0);
                end
                else
                begin
                    send_item(FUNC_ACCESS, {pg, off}, 1'b0, '0);
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/tlbfr_pkg.sv
src/tlbfr_ifs.sv
src/tlbfr_cam.sv
src/tlb_lookup_fifo_replace.sv
bench/tlb_lookup_fifo_replace_tb.sv
